// ===== rtl/core/openflow_message_deframer_core_assert.svh =====
// assertion macros used by the deframer top level
`ifndef OPENFLOW_MESSAGE_DEFRAMER_CORE_ASSERT_SVH
`define OPENFLOW_MESSAGE_DEFRAMER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define OFD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed: same-cycle rule");

// next-cycle implication, sampled on clk, off while in reset
`define OFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed: next-cycle rule");

`endif

// ===== rtl/core/ofd_pkg.sv =====
// types and constants shared by the openflow deframer modules
package ofd_pkg;

    localparam int NUM_STREAMS = 2;

    localparam logic [15:0] HDR_MIN_LEN = 16'd8;

    localparam logic [7:0] T_HELLO     = 8'd0;
    localparam logic [7:0] T_ERROR     = 8'd1;
    localparam logic [7:0] T_STATS_REQ = 8'd16;
    localparam logic [7:0] T_STATS_REP = 8'd17;

    localparam logic [15:0] ST_FLOW = 16'd1;
    localparam logic [15:0] ST_PORT = 16'd4;

    localparam logic [2:0] CLS_GENERIC   = 3'd0;
    localparam logic [2:0] CLS_HELLO     = 3'd1;
    localparam logic [2:0] CLS_FLOW_REQ  = 3'd2;
    localparam logic [2:0] CLS_FLOW_REP  = 3'd3;
    localparam logic [2:0] CLS_PORT_REP  = 3'd4;
    localparam logic [2:0] CLS_ERROR     = 3'd5;

    // header byte positions
    localparam logic [15:0] POS_VERSION = 16'd0;
    localparam logic [15:0] POS_TYPE    = 16'd1;
    localparam logic [15:0] POS_LEN_HI  = 16'd2;
    localparam logic [15:0] POS_LEN_LO  = 16'd3;
    localparam logic [15:0] POS_SUB_HI  = 16'd8;
    localparam logic [15:0] POS_SUB_LO  = 16'd9;
    localparam logic [15:0] POS_CODE_HI = 16'd10;
    localparam logic [15:0] POS_CODE_LO = 16'd11;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       direction;
    } item_t;

    typedef struct packed {
        logic        direction;
        logic [2:0]  msg_class;
        logic [15:0] msg_length;
        logic [7:0]  msg_version;
        logic [15:0] error_type;
        logic [15:0] error_code;
        logic        bad_length;
    } result_t;

    // handshake between the pipeline stages
    typedef struct packed {
        logic step;
        logic slot_free;
    } pipe_ctrl_t;

    function automatic logic [2:0] classify(input logic [7:0] typ, input logic [15:0] sub);
        logic [2:0] cls;
        begin
            cls = CLS_GENERIC;
            if (typ == T_HELLO)
                cls = CLS_HELLO;
            else if (typ == T_ERROR)
                cls = CLS_ERROR;
            else if (typ == T_STATS_REQ && sub == ST_FLOW)
                cls = CLS_FLOW_REQ;
            else if (typ == T_STATS_REP && sub == ST_FLOW)
                cls = CLS_FLOW_REP;
            else if (typ == T_STATS_REP && sub == ST_PORT)
                cls = CLS_PORT_REP;
            return cls;
        end
    endfunction

endpackage

// ===== rtl/core/ofd_in_stage.sv =====
// input register of the deframer pipeline
module ofd_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               direction,
    input  ofd_pkg::pipe_ctrl_t ctrl,
    output logic               item_valid,
    output ofd_pkg::item_t     item
);

    logic           valid_reg;
    logic           valid_next;
    ofd_pkg::item_t item_reg;

    assign in_ready = !valid_reg || ctrl.step;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
            valid_next = 1'b1;
        else if (ctrl.step)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.data_byte <= data_byte;
            item_reg.direction <= direction;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== rtl/core/ofd_framer.sv =====
// per-stream message position, header capture and classification
module ofd_framer
(
    input  logic               clk,
    input  logic               rst_n,
    input  ofd_pkg::pipe_ctrl_t ctrl,
    input  ofd_pkg::item_t     item,
    output logic               res_valid,
    output ofd_pkg::result_t   res
);

    logic [15:0] pos_reg  [ofd_pkg::NUM_STREAMS];
    logic [15:0] len_reg  [ofd_pkg::NUM_STREAMS];
    logic [7:0]  typ_reg  [ofd_pkg::NUM_STREAMS];
    logic [7:0]  ver_reg  [ofd_pkg::NUM_STREAMS];
    logic [15:0] sub_reg  [ofd_pkg::NUM_STREAMS];
    logic [15:0] code_reg [ofd_pkg::NUM_STREAMS];

    logic        stream_ok;
    logic        update;
    logic [15:0] pos;
    logic        first;
    logic [15:0] len_base;
    logic [7:0]  typ_base;
    logic [7:0]  ver_base;
    logic [15:0] sub_base;
    logic [15:0] code_base;
    logic [15:0] pos_next;
    logic [15:0] len_next;
    logic [7:0]  typ_next;
    logic [7:0]  ver_next;
    logic [15:0] sub_next;
    logic [15:0] code_next;
    logic        bad;
    logic [15:0] eff;
    logic        last;
    logic [2:0]  cls;

    assign stream_ok = (32'(item.direction) < ofd_pkg::NUM_STREAMS);
    assign update    = ctrl.step && stream_ok;

    always_comb
    begin
        pos   = pos_reg[item.direction];
        first = (pos == ofd_pkg::POS_VERSION);

        // fields clear at the start of each message
        len_base  = first ? 16'd0 : len_reg[item.direction];
        typ_base  = first ? 8'd0  : typ_reg[item.direction];
        ver_base  = first ? 8'd0  : ver_reg[item.direction];
        sub_base  = first ? 16'd0 : sub_reg[item.direction];
        code_base = first ? 16'd0 : code_reg[item.direction];

        ver_next  = (pos == ofd_pkg::POS_VERSION) ? item.data_byte : ver_base;
        typ_next  = (pos == ofd_pkg::POS_TYPE) ? item.data_byte : typ_base;
        len_next  = len_base;
        sub_next  = sub_base;
        code_next = code_base;
        case (pos)
            ofd_pkg::POS_LEN_HI:  len_next  = {item.data_byte, len_base[7:0]};
            ofd_pkg::POS_LEN_LO:  len_next  = {len_base[15:8], item.data_byte};
            ofd_pkg::POS_SUB_HI:  sub_next  = {item.data_byte, sub_base[7:0]};
            ofd_pkg::POS_SUB_LO:  sub_next  = {sub_base[15:8], item.data_byte};
            ofd_pkg::POS_CODE_HI: code_next = {item.data_byte, code_base[7:0]};
            ofd_pkg::POS_CODE_LO: code_next = {code_base[15:8], item.data_byte};
            default: ;
        endcase

        // short length field is framed as a bare header
        bad  = (len_next < ofd_pkg::HDR_MIN_LEN);
        eff  = bad ? ofd_pkg::HDR_MIN_LEN : len_next;
        last = (({1'b0, pos} + 17'd1) >= {1'b0, eff});

        pos_next = last ? 16'd0 : pos + 16'd1;
        cls      = ofd_pkg::classify(typ_next, sub_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ofd_pkg::NUM_STREAMS; i++)
            begin
                pos_reg[i]  <= 16'd0;
                len_reg[i]  <= 16'd0;
                typ_reg[i]  <= 8'd0;
                ver_reg[i]  <= 8'd0;
                sub_reg[i]  <= 16'd0;
                code_reg[i] <= 16'd0;
            end
        end
        else if (update)
        begin
            pos_reg[item.direction]  <= pos_next;
            len_reg[item.direction]  <= len_next;
            typ_reg[item.direction]  <= typ_next;
            ver_reg[item.direction]  <= ver_next;
            sub_reg[item.direction]  <= sub_next;
            code_reg[item.direction] <= code_next;
        end
    end

    assign res_valid       = update && last;
    assign res.direction   = item.direction;
    assign res.msg_class   = cls;
    assign res.msg_length  = eff;
    assign res.msg_version = ver_next;
    assign res.error_type  = (cls == ofd_pkg::CLS_ERROR) ? sub_next : 16'd0;
    assign res.error_code  = (cls == ofd_pkg::CLS_ERROR) ? code_next : 16'd0;
    assign res.bad_length  = bad;

endmodule

// ===== rtl/core/ofd_out_stage.sv =====
// result register of the deframer pipeline
module ofd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  ofd_pkg::result_t res,
    input  logic             out_ready,
    output logic             out_valid,
    output logic             slot_free,
    output ofd_pkg::result_t result
);

    logic             valid_reg;
    logic             valid_next;
    ofd_pkg::result_t result_reg;

    // the slot can be refilled in the cycle it drains
    assign slot_free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_valid)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            result_reg <= res;
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

// ===== rtl/core/openflow_message_deframer_core.sv =====
// top level of the openflow message deframer
//
// channel   signals                          role
// input     in_valid/in_ready, data_byte,    one payload byte, tagged with its stream
//           direction
// output    out_valid/out_ready, out_*,      one item per completed message
//           msg_*, error_*, bad_length
//
// one byte is taken every cycle while the result register can drain; out_valid rises
// once the last byte has passed the input register and then the result register
// the rate is set by the single pass from the input register through the
// per-stream state update into the result register
// reset clears every stream to message start with all captured fields zero
// a stalled result holds every byte in the input register, whether or not that byte
// ends a message; bytes move again in the cycle the result register drains
`include "openflow_message_deframer_core_assert.svh"

module openflow_message_deframer_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        direction,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_direction,
    output logic [2:0]  msg_class,
    output logic [15:0] msg_length,
    output logic [7:0]  msg_version,
    output logic [15:0] error_type,
    output logic [15:0] error_code,
    output logic        bad_length
);

    ofd_pkg::pipe_ctrl_t ctrl;
    ofd_pkg::item_t      item;
    ofd_pkg::result_t    res;
    ofd_pkg::result_t    result;
    logic                item_valid;
    logic                res_valid;
    logic                slot_free;
    logic                res_pending;

    // a byte moves on only when its result, if any, has somewhere to go
    always_comb
    begin
        res_pending    = 1'b0;
        ctrl.slot_free = slot_free;
        ctrl.step      = item_valid && slot_free;
    end

    ofd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .direction  (direction),
        .ctrl       (ctrl),
        .item_valid (item_valid),
        .item       (item)
    );

    // per-stream framing state and header capture
    ofd_framer u_framer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    ofd_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid || res_pending),
        .res       (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .slot_free (slot_free),
        .result    (result)
    );

    assign out_direction = result.direction;
    assign msg_class     = result.msg_class;
    assign msg_length    = result.msg_length;
    assign msg_version   = result.msg_version;
    assign error_type    = result.error_type;
    assign error_code    = result.error_code;
    assign bad_length    = result.bad_length;

    // a short header length is always reported as a bare header
    `OFD_ASSERT_IMPL(a_bad_len_is_min, out_valid && bad_length, msg_length == ofd_pkg::HDR_MIN_LEN)
    // error words only travel with an error message
    `OFD_ASSERT_IMPL(a_err_words_zero, out_valid && (msg_class != ofd_pkg::CLS_ERROR),
                     (error_type == 16'd0) && (error_code == 16'd0))
    // a held byte stays in the input register until it moves on
    `OFD_ASSERT_NEXT(a_item_held, item_valid && !ctrl.step, item_valid)
    // a result is never loaded while the slot is full and not draining
    `OFD_ASSERT_IMPL(a_no_overwrite, res_valid, slot_free)

endmodule
